/* rtl/kedw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package kedw_pkg;

    localparam int KEY_W   = 64;
    localparam int TIME_W  = 48;
    localparam int COUNT_W = 32;
    localparam int CFG_W   = 48;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_EXPIRY_TICKS = 1'b1;

    localparam logic [TIME_W-1:0]  WINDOW_RESET = 48'd1000000000;
    localparam logic [TIME_W-1:0]  IDLE_RESET   = 48'd60000000000;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] repeats;
        logic [TIME_W-1:0]  delivered_time;
    } entry_t;

    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] then_time;
        logic [TIME_W-1:0] limit;
    } age_req_t;

    typedef struct packed {
        logic below;
    } age_rsp_t;

endpackage

`default_nettype wire

/* rtl/kedw_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface kedw_in_if
    import kedw_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KEY_W-1:0]  event_key;
    logic [TIME_W-1:0] time_now;

    modport source (output valid, output event_key, output time_now, input ready);
    modport sink   (input valid, input event_key, input time_now, output ready);
endinterface

interface kedw_out_if
    import kedw_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               suppress;
    logic [COUNT_W-1:0] repeat_count;
    logic               stored;

    modport source (output valid, output suppress, output repeat_count, output stored,
                    input ready);
    modport sink   (input valid, input suppress, input repeat_count, input stored,
                    output ready);
endinterface

`default_nettype wire

/* rtl/kedw_age_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

module kedw_age_unit
    import kedw_pkg::*;
(
    input  age_req_t req,
    output age_rsp_t rsp
);

    logic [TIME_W-1:0] age;

    // wrap modulo the timestamp width
    assign age       = req.now - req.then_time;
    assign rsp.below = (age < req.limit);

endmodule

`default_nettype wire

/* rtl/keyed_event_dedup_window.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Beat contents                        | Handshake
// evt     | in  | event_key[63:0], time_now[47:0]      | valid/ready
// res     | out | suppress, repeat_count[31:0], stored | valid/ready
// cfg     | in  | cfg_index[0], cfg_data[47:0]         | cfg_we, no wait
//
// Each event is handled in order: an accept step, one walk over the table through
// its single registered read port, and a decide/write-back step. Expiry and
// window tests share one 48-bit age unit. After reset a clearing pass zeroes
// every table entry with evt.ready low.
// A result beat holds until taken; the next event may be accepted meanwhile but
// its decide cycle waits for the result register to empty.

module keyed_event_dedup_window
    import kedw_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    kedw_in_if.sink                   evt,
    kedw_out_if.source                res,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TIME_W-1:0]  window_reg, window_next;
    logic [TIME_W-1:0]  idle_reg, idle_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic               hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [COUNT_W-1:0] hit_rep_reg, hit_rep_next;
    logic [TIME_W-1:0]  hit_time_reg, hit_time_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic               res_valid_reg, res_valid_next;
    logic               suppress_reg, suppress_next;
    logic [COUNT_W-1:0] repeat_count_reg, repeat_count_next;
    logic               stored_reg, stored_next;

    entry_t             mem [TABLE_ENTRIES];
    entry_t             rd_data_reg;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;

    logic [IDX_W-1:0]   proc_idx;
    logic               live;
    age_req_t           age_req;
    age_rsp_t           age_rsp;

    kedw_age_unit u_age (
        .req (age_req),
        .rsp (age_rsp)
    );

    assign proc_idx = cnt_reg[IDX_W-1:0] - IDX_W'(1);
    assign live     = rd_data_reg.valid && age_rsp.below;

    assign evt.ready        = (state_reg == ST_IDLE);
    assign res.valid        = res_valid_reg;
    assign res.suppress     = suppress_reg;
    assign res.repeat_count = repeat_count_reg;
    assign res.stored       = stored_reg;

    always_comb
    begin
        age_req.now = now_reg;
        if (state_reg == ST_SCAN)
        begin
            age_req.then_time = rd_data_reg.delivered_time;
            age_req.limit     = idle_reg;
        end
        else
        begin
            age_req.then_time = hit_time_reg;
            age_req.limit     = window_reg;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        window_next       = window_reg;
        idle_next         = idle_reg;
        key_next          = key_reg;
        now_next          = now_reg;
        hit_found_next    = hit_found_reg;
        hit_idx_next      = hit_idx_reg;
        hit_rep_next      = hit_rep_reg;
        hit_time_next     = hit_time_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        res_valid_next    = res_valid_reg && !res.ready;
        suppress_next     = suppress_reg;
        repeat_count_next = repeat_count_reg;
        stored_next       = stored_reg;
        rd_en             = 1'b0;
        rd_addr           = cnt_reg[IDX_W-1:0];
        wr_en             = 1'b0;
        wr_addr           = proc_idx;
        wr_data           = rd_data_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_TICKS:      window_next = cfg_data;
                REG_IDLE_EXPIRY_TICKS: idle_next   = cfg_data;
                default:               ;
            endcase
        end

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg[IDX_W-1:0];
                wr_data = '0;
                if (cnt_reg == CNT_W'(TABLE_ENTRIES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (evt.valid)
                begin
                    key_next        = evt.event_key;
                    now_next        = evt.time_now;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    cnt_next        = '0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rd_en = (cnt_reg < CNT_W'(TABLE_ENTRIES));
                if (cnt_reg != '0)
                begin
                    // drop idle entry
                    if (rd_data_reg.valid && !age_rsp.below)
                    begin
                        wr_en         = 1'b1;
                        wr_data.valid = 1'b0;
                    end
                    if (live && rd_data_reg.key == key_reg && !hit_found_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = proc_idx;
                        hit_rep_next   = rd_data_reg.repeats;
                        hit_time_next  = rd_data_reg.delivered_time;
                    end
                    if (!live && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = proc_idx;
                    end
                end
                if (cnt_reg == CNT_W'(TABLE_ENTRIES))
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DECIDE:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next    = 1'b1;
                    suppress_next     = 1'b0;
                    repeat_count_next = '0;
                    stored_next       = 1'b1;
                    wr_data.valid     = 1'b1;
                    wr_data.key       = key_reg;
                    wr_data.repeats   = '0;
                    wr_data.delivered_time = now_reg;
                    if (!hit_found_reg)
                    begin
                        wr_en       = free_found_reg;
                        wr_addr     = free_idx_reg;
                        stored_next = free_found_reg;
                    end
                    else if (age_rsp.below)
                    begin
                        // suppress and count, saturating
                        wr_en          = 1'b1;
                        wr_addr        = hit_idx_reg;
                        wr_data.delivered_time = hit_time_reg;
                        wr_data.repeats = (hit_rep_reg == COUNT_MAX) ? hit_rep_reg
                                                                     : hit_rep_reg + COUNT_W'(1);
                        suppress_next  = 1'b1;
                    end
                    else
                    begin
                        wr_en             = 1'b1;
                        wr_addr           = hit_idx_reg;
                        repeat_count_next = hit_rep_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            cnt_reg          <= '0;
            window_reg       <= WINDOW_RESET;
            idle_reg         <= IDLE_RESET;
            key_reg          <= '0;
            now_reg          <= '0;
            hit_found_reg    <= 1'b0;
            hit_idx_reg      <= '0;
            hit_rep_reg      <= '0;
            hit_time_reg     <= '0;
            free_found_reg   <= 1'b0;
            free_idx_reg     <= '0;
            res_valid_reg    <= 1'b0;
            suppress_reg     <= 1'b0;
            repeat_count_reg <= '0;
            stored_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            window_reg       <= window_next;
            idle_reg         <= idle_next;
            key_reg          <= key_next;
            now_reg          <= now_next;
            hit_found_reg    <= hit_found_next;
            hit_idx_reg      <= hit_idx_next;
            hit_rep_reg      <= hit_rep_next;
            hit_time_reg     <= hit_time_next;
            free_found_reg   <= free_found_next;
            free_idx_reg     <= free_idx_next;
            res_valid_reg    <= res_valid_next;
            suppress_reg     <= suppress_next;
            repeat_count_reg <= repeat_count_next;
            stored_reg       <= stored_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/kedw_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module kedw_checker
    import kedw_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               evt_valid,
    input wire logic               evt_ready,
    input wire logic               res_valid,
    input wire logic               res_ready,
    input wire logic               suppress,
    input wire logic [COUNT_W-1:0] repeat_count,
    input wire logic               stored
);

    // hold a stalled result beat
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(suppress)
            && $stable(repeat_count) && $stable(stored))
        else $error("result beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_ready |=> !evt_ready)
        else $error("event accepted while previous one still in work");

    a_suppress_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && suppress |-> repeat_count == '0 && stored)
        else $error("suppressed beat carries count or not-stored flag");

    a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !stored |-> !suppress && repeat_count == '0)
        else $error("not-stored beat is not a plain delivery");

endmodule

bind keyed_event_dedup_window kedw_checker u_kedw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .evt_valid    (evt.valid),
    .evt_ready    (evt.ready),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .suppress     (res.suppress),
    .repeat_count (res.repeat_count),
    .stored       (res.stored)
);

`default_nettype wire
